[rtl/adsr_pkg.sv]
`default_nettype none

package adsr_pkg;

   localparam int LEVEL_W = 25;
   localparam int STAGE_W = 3;
   localparam int NOTE_W = 7;
   localparam int CHAN_W = 4;
   localparam int RELS_W = 20;
   localparam int CSR_W = 25;
   localparam int CSR_IDX_W = 2;
   localparam int FUNC_W = 2;
   localparam int VOICE_W = 3;
   localparam int MAX_REPORT = 8;

   localparam logic [LEVEL_W-1:0] FULL_SCALE = 25'h100_0000;
   localparam logic [LEVEL_W-1:0] RELEASE_FLOOR = 25'd16777;

   // request functions
   localparam logic [FUNC_W-1:0] FUNC_NOTE_ON = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_NOTE_OFF = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ALL_OFF = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd3;

   // envelope stages
   localparam logic [STAGE_W-1:0] STAGE_IDLE = 3'd0;
   localparam logic [STAGE_W-1:0] STAGE_ATTACK = 3'd1;
   localparam logic [STAGE_W-1:0] STAGE_DECAY = 3'd2;
   localparam logic [STAGE_W-1:0] STAGE_SUSTAIN = 3'd3;
   localparam logic [STAGE_W-1:0] STAGE_RELEASE = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_STEP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_STEP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SUSTAIN_LEVEL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_SAMPLES = 2'd3;

   // one voice slot as held in the state memory
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [STAGE_W-1:0] stage;
      logic [LEVEL_W-1:0] rel_step;
      logic [NOTE_W-1:0]  note;
      logic [CHAN_W-1:0]  channel;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

endpackage

`default_nettype wire

[rtl/adsr_ram.sv]
`default_nettype none

module adsr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/adsr_div.sv]
`default_nettype none

module adsr_div
   import adsr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [LEVEL_W-1:0] dividend,
   input  wire logic [RELS_W-1:0]  divisor,
   output logic                    done,
   output logic      [LEVEL_W-1:0] quotient
);

   localparam int CNT_W = $clog2(LEVEL_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LEVEL_W - 1);

   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [RELS_W-1:0]  rem_ff, rem_in;
   logic [LEVEL_W-1:0] quo_ff, quo_in;
   logic [RELS_W-1:0]  div_ff, div_in;
   logic [RELS_W:0]    trial;
   logic               fits;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial = {rem_ff, quo_ff[LEVEL_W-1]};
      fits = trial >= {1'b0, div_ff};
      run_in = run_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      div_in = div_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
         div_in = divisor;
      end else if (run_ff) begin
         rem_in = fits ? RELS_W'(trial - {1'b0, div_ff}) : trial[RELS_W-1:0];
         quo_in = {quo_ff[LEVEL_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[rtl/polyphonic_adsr_envelope_bank.sv]
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_func, req_channel, req_note
// rsp       out        rsp_valid / rsp_ready  rsp_voice, rsp_level, rsp_stage,
//                                             rsp_active, rsp_last
// csr       in         csr_we                 csr_index, csr_wdata
//
// a tick walks the slot memory one slot per cycle while rsp does not stall.
// note-off walks the same way and, when release_samples is nonzero, waits
// on the serial divider for each matching slot. note-on scans the active
// bits for a free slot. all notes off clears the active bits on accept. reset
// clears the active bits and control state and loads the csr defaults; no
// memory clearing pass is needed: an inactive slot reads as idle at level 0.
`default_nettype none

module polyphonic_adsr_envelope_bank
   import adsr_pkg::*;
#(
   parameter int VOICES = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [FUNC_W-1:0]    req_func,
   input  wire logic [CHAN_W-1:0]    req_channel,
   input  wire logic [NOTE_W-1:0]    req_note,

   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic      [VOICE_W-1:0]   rsp_voice,
   output logic      [LEVEL_W-1:0]   rsp_level,
   output logic      [STAGE_W-1:0]   rsp_stage,
   output logic                      rsp_active,
   output logic                      rsp_last,

   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int REPORT_N = (VOICES < MAX_REPORT) ? VOICES : MAX_REPORT;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);
   localparam logic [IDX_W-1:0] RPT_LAST = IDX_W'(REPORT_N - 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_FIND = 4'b0010,
      S_SCAN = 4'b0100,
      S_DIV  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    steal_ff, steal_in;
   logic [VOICES-1:0]   active_ff, active_in;

   logic [FUNC_W-1:0]   cmd_func_ff, cmd_func_in;
   logic [CHAN_W-1:0]   cmd_channel_ff, cmd_channel_in;
   logic [NOTE_W-1:0]   cmd_note_ff, cmd_note_in;

   logic [LEVEL_W-1:0]  attack_ff, attack_in;
   logic [LEVEL_W-1:0]  decay_ff, decay_in;
   logic [LEVEL_W-1:0]  sustain_ff, sustain_in;
   logic [RELS_W-1:0]   rel_samples_ff, rel_samples_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [VOICE_W-1:0]  rsp_voice_ff, rsp_voice_in;
   logic [LEVEL_W-1:0]  rsp_level_ff, rsp_level_in;
   logic [STAGE_W-1:0]  rsp_stage_ff, rsp_stage_in;
   logic                rsp_active_ff, rsp_active_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   slot_type            wr_slot;
   logic [IDX_W-1:0]    rd_addr;
   slot_type            cur;

   logic                div_start;
   logic                div_done;
   logic [LEVEL_W-1:0]  div_quo;

   logic [LEVEL_W-1:0]  sus_lvl;
   logic [LEVEL_W:0]    sum;
   logic [LEVEL_W:0]    lim;
   logic [LEVEL_W-1:0]  nxt_level;
   logic [STAGE_W-1:0]  nxt_stage;
   logic                nxt_active;

   logic                accept;
   logic                act;
   logic [IDX_W-1:0]    nxt_idx;
   logic                emit;
   logic                stall;
   logic                match;
   logic                advance;

   adsr_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (VOICES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_slot),
      .rd_addr (rd_addr),
      .rd_data (cur)
   );

   adsr_div u_rel_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cur.level),
      .divisor  (rel_samples_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // one sample of envelope for the slot in the read register
   always_comb begin
      sus_lvl = (sustain_ff > FULL_SCALE) ? FULL_SCALE : sustain_ff;
      sum = {1'b0, cur.level} + {1'b0, attack_ff};
      lim = '0;
      nxt_level = cur.level;
      nxt_stage = cur.stage;
      nxt_active = 1'b1;
      case (cur.stage)
         STAGE_ATTACK: begin
            if (sum >= {1'b0, FULL_SCALE}) begin
               nxt_level = FULL_SCALE;
               nxt_stage = STAGE_DECAY;
            end else begin
               nxt_level = sum[LEVEL_W-1:0];
            end
         end
         STAGE_DECAY: begin
            lim = {1'b0, sus_lvl} + {1'b0, decay_ff};
            if ({1'b0, cur.level} <= lim) begin
               nxt_level = sus_lvl;
               nxt_stage = STAGE_SUSTAIN;
            end else begin
               nxt_level = cur.level - decay_ff;
            end
         end
         STAGE_SUSTAIN: begin
            nxt_level = sus_lvl;
         end
         STAGE_RELEASE: begin
            lim = {1'b0, cur.rel_step} + {1'b0, RELEASE_FLOOR};
            if ({1'b0, cur.level} <= lim) begin
               nxt_level = '0;
               nxt_stage = STAGE_IDLE;
               nxt_active = 1'b0;
            end else begin
               nxt_level = cur.level - cur.rel_step;
            end
         end
         default: begin
            nxt_level = '0;
            nxt_stage = STAGE_IDLE;
            nxt_active = 1'b0;
         end
      endcase
   end

   always_comb begin
      accept = req_valid && (state_ff == S_IDLE);
      act = active_ff[idx_ff];
      nxt_idx = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
      emit = (32'(idx_ff) < REPORT_N);
      stall = emit && rsp_valid_ff && !rsp_ready;
      match = act && (cur.channel == cmd_channel_ff) && (cur.note == cmd_note_ff);

      state_in = state_ff;
      idx_in = idx_ff;
      steal_in = steal_ff;
      active_in = active_ff;
      cmd_func_in = cmd_func_ff;
      cmd_channel_in = cmd_channel_ff;
      cmd_note_in = cmd_note_ff;
      advance = 1'b0;
      div_start = 1'b0;
      wr_en = 1'b0;
      wr_addr = idx_ff;
      wr_slot = cur;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_voice_in = rsp_voice_ff;
      rsp_level_in = rsp_level_ff;
      rsp_stage_in = rsp_stage_ff;
      rsp_active_in = rsp_active_ff;
      rsp_last_in = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_func_in = req_func;
               cmd_channel_in = req_channel;
               cmd_note_in = req_note;
               idx_in = '0;
               unique case (req_func)
                  FUNC_NOTE_ON:  state_in = S_FIND;
                  FUNC_ALL_OFF:  active_in = '0;
                  FUNC_NOTE_OFF,
                  FUNC_TICK:     state_in = S_SCAN;
                  default:       state_in = S_IDLE;
               endcase
            end
         end
         S_FIND: begin
            if (!act || idx_ff == LAST_IDX) begin
               wr_en = 1'b1;
               wr_addr = act ? steal_ff : idx_ff;
               if (act) begin
                  steal_in = (steal_ff == LAST_IDX) ? '0 : steal_ff + 1'b1;
               end
               wr_slot.level = '0;
               wr_slot.stage = STAGE_ATTACK;
               wr_slot.rel_step = '0;
               wr_slot.note = cmd_note_ff;
               wr_slot.channel = cmd_channel_ff;
               active_in[wr_addr] = 1'b1;
               idx_in = '0;
               state_in = S_IDLE;
            end else begin
               idx_in = nxt_idx;
            end
         end
         S_SCAN: begin
            if (cmd_func_ff == FUNC_TICK) begin
               if (!stall) begin
                  advance = 1'b1;
                  if (act) begin
                     wr_en = 1'b1;
                     wr_slot.level = nxt_level;
                     wr_slot.stage = nxt_stage;
                     active_in[idx_ff] = nxt_active;
                  end
                  if (emit) begin
                     rsp_valid_in = 1'b1;
                     rsp_voice_in = VOICE_W'(idx_ff);
                     rsp_level_in = act ? nxt_level : '0;
                     rsp_stage_in = act ? nxt_stage : STAGE_IDLE;
                     rsp_active_in = act && nxt_active;
                     rsp_last_in = (idx_ff == RPT_LAST);
                  end
               end
            end else if (match && rel_samples_ff != '0) begin
               div_start = 1'b1;
               state_in = S_DIV;
            end else begin
               advance = 1'b1;
               if (match) begin
                  wr_en = 1'b1;
                  wr_slot.stage = STAGE_RELEASE;
                  wr_slot.rel_step = FULL_SCALE;
               end
            end
         end
         S_DIV: begin
            // read data holds while the divider runs: same address, no write
            if (div_done) begin
               advance = 1'b1;
               wr_en = 1'b1;
               wr_slot.stage = STAGE_RELEASE;
               wr_slot.rel_step = (div_quo == '0) ? LEVEL_W'(1) : div_quo;
               state_in = S_SCAN;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (advance) begin
         idx_in = nxt_idx;
         if (idx_ff == LAST_IDX) begin
            state_in = S_IDLE;
         end
      end

      // read one slot ahead so the scan walk moves a slot per cycle unless it stalls or waits on the divider
      if (state_ff == S_IDLE) begin
         rd_addr = '0;
      end else if (advance) begin
         rd_addr = nxt_idx;
      end else begin
         rd_addr = idx_ff;
      end
   end

   always_comb begin
      attack_in = attack_ff;
      decay_in = decay_ff;
      sustain_in = sustain_ff;
      rel_samples_in = rel_samples_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ATTACK_STEP:     attack_in = csr_wdata;
            CSR_DECAY_STEP:      decay_in = csr_wdata;
            CSR_SUSTAIN_LEVEL:   sustain_in = csr_wdata;
            CSR_RELEASE_SAMPLES: rel_samples_in = csr_wdata[RELS_W-1:0];
            default:             attack_in = attack_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
         steal_ff <= '0;
         active_ff <= '0;
         attack_ff <= FULL_SCALE;
         decay_ff <= FULL_SCALE;
         sustain_ff <= FULL_SCALE;
         rel_samples_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         steal_ff <= steal_in;
         active_ff <= active_in;
         attack_ff <= attack_in;
         decay_ff <= decay_in;
         sustain_ff <= sustain_in;
         rel_samples_ff <= rel_samples_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_func_ff <= cmd_func_in;
      cmd_channel_ff <= cmd_channel_in;
      cmd_note_ff <= cmd_note_in;
      rsp_voice_ff <= rsp_voice_in;
      rsp_level_ff <= rsp_level_in;
      rsp_stage_ff <= rsp_stage_in;
      rsp_active_ff <= rsp_active_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_voice = rsp_voice_ff;
   assign rsp_level = rsp_level_ff;
   assign rsp_stage = rsp_stage_ff;
   assign rsp_active = rsp_active_ff;
   assign rsp_last = rsp_last_ff;

endmodule

`default_nettype wire
